@@ hdl/lru_slot_cache_with_locks_top_defines.svh @@
// Assertion macros for the LRU slot cache top level
`ifndef LRU_SLOT_CACHE_WITH_LOCKS_TOP_DEFINES_SVH
`define LRU_SLOT_CACHE_WITH_LOCKS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSCL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lscl assertion failed");

// next-cycle implication, checked outside reset
`define LSCL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lscl assertion failed");

`endif

@@ hdl/lscl_pkg.sv @@
// Shared types and constants for the LRU slot cache
`default_nettype none
package lscl_pkg;

   localparam int IDX_W    = 8;   // slot index, up to 256 slots
   localparam int CNT_W    = 9;   // slot count, up to 256
   localparam int PIC_W    = 11;
   localparam int STAMP_W  = 31;  // use clock saturates below 2^31

   localparam int SLOTS_DEF = 64;
   localparam int PICS_DEF  = 2048;

   localparam logic [STAMP_W-1:0] CLOCK_TOP  = 31'h7fff_fffe;
   localparam logic [STAMP_W-1:0] SCAN_START = 31'h7fff_ffff;

   // input op codes
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_FRAME  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;   // unused code, answers done

   // result status codes
   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_FILL    = 3'd1;
   localparam logic [2:0] ST_EVICT   = 3'd2;
   localparam logic [2:0] ST_DEFER   = 3'd3;
   localparam logic [2:0] ST_REFUSED = 3'd4;
   localparam logic [2:0] ST_NOSLOT  = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   // csr register indexes
   localparam logic CSR_SLOTS = 1'b0;
   localparam logic CSR_BASE  = 1'b1;

   // scan record handed from cell to cell
   typedef struct packed {
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic               empty;
      logic [IDX_W-1:0]   empty_idx;
      logic               found;
      logic [STAMP_W-1:0] best;
      logic [IDX_W-1:0]   best_idx;
      logic [PIC_W-1:0]   best_owner;
   } scan_type;

   // write command broadcast to all cells
   typedef struct packed {
      logic               en;
      logic               clear;
      logic               fill;
      logic               lock;
      logic [IDX_W-1:0]   idx;
      logic [PIC_W-1:0]   owner;
      logic [STAMP_W-1:0] stamp;
   } wr_type;

endpackage
`default_nettype wire

@@ hdl/lru_slot_cache_with_locks_top.sv @@
// Top level of the LRU texture slot cache with locks
// An access scans and then decides: a scan record walks the row of slot
// cells one cell per cycle, checking for a hit, the lowest empty slot and the oldest
// unlocked stamp, and the decide step writes the chosen cell. Frame end, clear and
// out-of-range images go straight to decide. One item is in work at a time; the result
// sits in an output register, so a stalled result only holds the block in S_DECIDE.
`default_nettype none
module lru_slot_cache_with_locks_top import lscl_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF,
   parameter int PICS  = PICS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_op,
   input  wire logic [10:0]  req_pic_id,
   input  wire logic         req_safe,
   input  wire logic         req_lock,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_char_number,
   output logic              rsp_evicted_valid,
   output logic [10:0]       rsp_evicted_pic,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_wdata
);

`include "lru_slot_cache_with_locks_top_defines.svh"

   localparam int SCW = $clog2(SLOTS + 1);
   localparam logic [SCW-1:0] SCAN_LAST = SCW'(SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOTS_N = CNT_W'(SLOTS);
   localparam logic [16:0] PICS_L = 17'(PICS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [SCW-1:0]     cnt_ff, cnt_in;
   logic [1:0]         op_ff;
   logic [PIC_W-1:0]   pic_ff;
   logic               safe_ff, lock_ff;
   logic [6:0]         slots_ff;
   logic [15:0]        base_ff;
   logic [STAMP_W-1:0] use_clock_ff, use_clock_in;
   logic [STAMP_W-1:0] frame_ff, frame_in;
   logic [STAMP_W-1:0] prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         status_ff, status_in;
   logic [15:0]        char_ff, char_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [PIC_W-1:0]   ev_pic_ff, ev_pic_in;

   logic               req_xfer, rsp_xfer, out_free, deciding;
   logic [CNT_W-1:0]   n;
   logic               pic_oor;
   logic [STAMP_W-1:0] next_stamp;
   logic               safe_eff;
   logic [IDX_W-1:0]   slot_sel;
   scan_type           rec;
   scan_type           scan_init;
   wr_type             wr;
   scan_type           links [0:SLOTS];

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign deciding = (state_ff == S_DECIDE) && out_free;
   assign req_stall = (state_ff != S_IDLE);

   // effective slot count, clipped at SLOTS
   assign n = ({2'b0, slots_ff} > SLOTS_N) ? SLOTS_N : {2'b0, slots_ff};
   assign pic_oor = {6'b0, req_pic_id} >= PICS_L;

   // fresh scan record entering cell zero
   always_comb begin
      scan_init            = '0;
      scan_init.best       = SCAN_START;
   end
   assign links[0] = scan_init;

   // row of slot cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      lscl_cell #(.INDEX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (links[g]),
         .scan_out (links[g+1]),
         .pic      (pic_ff),
         .n        (n),
         .wr       (wr)
      );
   end
   assign rec = links[SLOTS];

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cnt_in   = '0;
               state_in = (req_op == OP_ACCESS && !pic_oor) ? S_SCAN : S_DECIDE;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SCAN_LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign next_stamp = (use_clock_ff < CLOCK_TOP) ? use_clock_ff + 1'b1 : use_clock_ff;
   assign safe_eff   = safe_ff && !lock_ff;

   // decision and slot write
   always_comb begin
      wr           = '0;
      wr.owner     = pic_ff;
      wr.lock      = lock_ff;
      wr.stamp     = lock_ff ? '0 : next_stamp;
      use_clock_in = use_clock_ff;
      frame_in     = frame_ff;
      prev_in      = prev_ff;
      status_in    = ST_DONE;
      slot_sel     = '0;
      ev_valid_in  = 1'b0;
      ev_pic_in    = '0;
      char_in      = '0;
      if (deciding) begin
         unique case (op_ff)
            OP_ACCESS: begin
               priority if ({6'b0, pic_ff} >= PICS_L) begin
                  status_in = ST_NOSLOT;
               end else if (rec.hit) begin
                  status_in = ST_HIT;
                  slot_sel  = rec.hit_idx;
                  wr.en     = 1'b1;
               end else if (rec.empty) begin
                  status_in = ST_FILL;
                  slot_sel  = rec.empty_idx;
                  wr.en     = 1'b1;
                  wr.fill   = 1'b1;
               end else if (safe_eff && rec.best >= frame_ff) begin
                  status_in = ST_REFUSED;
               end else if (!rec.found) begin
                  status_in = ST_NOSLOT;
               end else begin
                  status_in   = (safe_eff && rec.best >= prev_ff) ? ST_DEFER : ST_EVICT;
                  slot_sel    = rec.best_idx;
                  wr.en       = 1'b1;
                  wr.fill     = 1'b1;
                  ev_valid_in = 1'b1;
                  ev_pic_in   = rec.best_owner;
               end
               if (wr.en) begin
                  char_in = base_ff + {8'b0, slot_sel};
                  if (!lock_ff) begin
                     use_clock_in = next_stamp;
                  end
               end
            end
            OP_FRAME: begin
               prev_in  = frame_ff;
               frame_in = use_clock_ff + 1'b1;
            end
            OP_CLEAR: begin
               wr.clear = 1'b1;
            end
            default: status_in = ST_DONE;
         endcase
      end
      wr.idx = slot_sel;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (deciding) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         use_clock_ff <= '0;
         frame_ff     <= 31'd1;
         prev_ff      <= 31'd1;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= 7'd48;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         use_clock_ff <= use_clock_in;
         frame_ff     <= frame_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLOTS: slots_ff <= csr_wdata[6:0];
               CSR_BASE:  base_ff  <= csr_wdata;
               default:   base_ff  <= base_ff;
            endcase
         end
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff   <= req_op;
         pic_ff  <= req_pic_id;
         safe_ff <= req_safe;
         lock_ff <= req_lock;
      end
      if (deciding) begin
         status_ff   <= status_in;
         char_ff     <= char_in;
         ev_valid_ff <= ev_valid_in;
         ev_pic_ff   <= ev_pic_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_char_number   = char_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_pic   = ev_pic_ff;

   `LSCL_ASSERT_NEXT(a_req_starts_work, req_xfer, state_ff != S_IDLE)
   `LSCL_ASSERT_NOW(a_write_only_decide, wr.en || wr.clear, state_ff == S_DECIDE)
   `LSCL_ASSERT_NOW(a_clock_saturates, 1'b1, use_clock_ff <= CLOCK_TOP)
   `LSCL_ASSERT_NOW(a_evict_status, rsp_valid_ff && ev_valid_ff,
                    status_ff == ST_EVICT || status_ff == ST_DEFER)

endmodule
`default_nettype wire

@@ hdl/lscl_cell.sv @@
// One slot cell: holds a slot's state and folds it into the passing scan record
`default_nettype none
module lscl_cell import lscl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire scan_type           scan_in,
   output scan_type                scan_out,
   input  wire logic [PIC_W-1:0]   pic,
   input  wire logic [CNT_W-1:0]   n,
   input  wire wr_type             wr
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic               valid_ff, valid_in;
   logic               locked_ff, locked_in;
   logic [PIC_W-1:0]   owner_ff, owner_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   scan_type           scan_ff, scan_next_in;
   logic               in_range;
   logic               sel;

   assign in_range = {1'b0, MY_IDX} < n;
   assign sel      = wr.en && (wr.idx == MY_IDX);

   // fold this slot into the record
   always_comb begin
      scan_next_in = scan_in;
      if (!scan_in.hit && valid_ff && owner_ff == pic) begin
         scan_next_in.hit     = 1'b1;
         scan_next_in.hit_idx = MY_IDX;
      end
      if (in_range && !scan_in.empty && !valid_ff) begin
         scan_next_in.empty     = 1'b1;
         scan_next_in.empty_idx = MY_IDX;
      end
      if (in_range && !locked_ff && stamp_ff < scan_in.best) begin
         scan_next_in.found      = 1'b1;
         scan_next_in.best       = stamp_ff;
         scan_next_in.best_idx   = MY_IDX;
         scan_next_in.best_owner = owner_ff;
      end
   end

   // slot update from the write command
   always_comb begin
      valid_in  = valid_ff;
      locked_in = locked_ff;
      owner_in  = owner_ff;
      stamp_in  = stamp_ff;
      if (wr.clear && !locked_ff) begin
         valid_in = 1'b0;
      end
      if (sel) begin
         stamp_in = wr.stamp;
         if (wr.fill) begin
            valid_in  = 1'b1;
            owner_in  = wr.owner;
            locked_in = wr.lock;
         end else begin
            locked_in = locked_ff | wr.lock;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         locked_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         locked_ff <= locked_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
      stamp_ff <= stamp_in;
      scan_ff  <= scan_next_in;
   end

   assign scan_out = scan_ff;

endmodule
`default_nettype wire
